/* rtl/toy_cpu_register_alu_step_assert.svh */
// Assertion macros for the toy CPU step block.
// Used by the top level; no other dependencies.
`ifndef TOY_CPU_REGISTER_ALU_STEP_ASSERT_SVH
`define TOY_CPU_REGISTER_ALU_STEP_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define TCPU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tcpu assertion failed");
// condition must never be seen out of reset
`define TCPU_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tcpu forbidden condition seen");
`else
`define TCPU_ASSERT(lbl, clk, rst_n, prop)
`define TCPU_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* rtl/tcpu_pkg.sv */
// Shared types and constants for the toy CPU step block.
// No dependencies.
`timescale 1ns / 1ps

package tcpu_pkg;

    // instruction opcodes; 13-15 are unused and behave as no-op
    typedef enum logic [3:0] {
        OP_STORE = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_JUMP  = 4'd5,
        OP_JIF   = 4'd6,
        OP_CMP   = 4'd7,
        OP_WMEM  = 4'd8,
        OP_RMEM  = 4'd9,
        OP_RREG  = 4'd10,
        OP_HALT  = 4'd11,
        OP_NOP   = 4'd12
    } op_t;

    // register select codes; 0-3 are the general registers
    localparam logic [2:0] REG_SP   = 3'd4;
    localparam logic [2:0] REG_BP   = 3'd5;
    localparam logic [2:0] REG_PC   = 3'd6;
    localparam logic [2:0] REG_FLAG = 3'd7;

    localparam int GEN_REGS  = 4;
    localparam int ALU_STEPS = 8;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_ALU,
        ST_MEM,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic       start;
        alu_op_t    op;
        logic [7:0] a;
        logic [7:0] b;
    } alu_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] result;
    } alu_rsp_t;

    typedef struct packed {
        logic       we;
        logic       re;
        logic [7:0] addr;
        logic [7:0] wdata;
    } mem_req_t;

endpackage

/* rtl/tcpu_alu.sv */
// Iterative 8-bit ALU: one shared adder/subtractor, shift-add multiply and
// restoring divide one bit per cycle. Depends on tcpu_pkg.
`timescale 1ns / 1ps

module tcpu_alu
    import tcpu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    localparam logic [2:0] LAST_CNT = 3'(ALU_STEPS - 1);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [2:0] cnt_reg, cnt_next;
    alu_op_t    op_reg, op_next;
    logic [7:0] a_reg, a_next;
    logic [7:0] b_reg, b_next;
    logic [7:0] acc_reg, acc_next;

    logic [8:0] add_x;
    logic [8:0] add_y;
    logic       add_sub;
    logic [9:0] sum;
    logic       last;

    // shared adder operand select
    always_comb
    begin
        add_x   = {1'b0, a_reg};
        add_y   = {1'b0, b_reg};
        add_sub = 1'b0;
        case (op_reg)
            ALU_ADD:
            begin
                add_sub = 1'b0;
            end
            ALU_SUB:
            begin
                add_sub = 1'b1;
            end
            ALU_MUL:
            begin
                add_x = {1'b0, acc_reg};
            end
            ALU_DIV:
            begin
                // partial remainder shifted left with next dividend bit
                add_x   = {acc_reg, a_reg[7]};
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
        sum = add_sub ? ({1'b0, add_x} - {1'b0, add_y}) : ({1'b0, add_x} + {1'b0, add_y});
    end

    // add and subtract finish in one step
    assign last = (op_reg == ALU_ADD || op_reg == ALU_SUB) ? 1'b1 : (cnt_reg == LAST_CNT);

    // step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            op_next   = req.op;
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = 8'd0;
        end
        else if (busy_reg)
        begin
            case (op_reg) inside
                ALU_ADD, ALU_SUB:
                begin
                    acc_next = sum[7:0];
                end
                ALU_MUL:
                begin
                    if (a_reg[0])
                    begin
                        acc_next = sum[7:0];
                    end
                    a_next = {1'b0, a_reg[7:1]};
                    b_next = {b_reg[6:0], 1'b0};
                end
                ALU_DIV:
                begin
                    // borrow means the divisor does not fit: keep shifted remainder
                    acc_next = sum[9] ? add_x[7:0] : sum[7:0];
                    a_next   = {a_reg[6:0], ~sum[9]};
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg + 3'd1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == ALU_DIV) ? a_reg : acc_reg;

endmodule

/* rtl/tcpu_mem.sv */
// Byte data memory with registered read and a clearing pass after reset.
// Depends on tcpu_pkg.
`timescale 1ns / 1ps

module tcpu_mem
    import tcpu_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  mem_req_t   req,
    output logic [7:0] rdata,
    output logic       busy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    mem_q_reg;
    logic          rd_range_reg;
    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_idx_reg, clr_idx_next;

    logic          in_range;
    logic          wr_en;
    logic [AW-1:0] wr_idx;
    logic [7:0]    wr_data;

    assign in_range = ({1'b0, req.addr} < 9'(DEPTH));

    // clearing pass owns the write port until it finishes
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg)
        begin
            wr_en   = 1'b1;
            wr_idx  = clr_idx_reg;
            wr_data = 8'd0;
            clr_idx_next = clr_idx_reg + AW'(1);
            if (clr_idx_reg == AW'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
        else
        begin
            wr_en   = req.we && in_range;
            wr_idx  = req.addr[AW-1:0];
            wr_data = req.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    // storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (req.re)
        begin
            mem_q_reg    <= mem[req.addr[AW-1:0]];
            rd_range_reg <= in_range;
        end
    end

    // out-of-range reads return zero
    assign rdata = rd_range_reg ? mem_q_reg : 8'd0;
    assign busy  = clearing_reg;

endmodule

/* rtl/toy_cpu_register_alu_step.sv */
// Toy CPU step: one instruction per input transaction, one result each.
// Path from accept to out_valid: simple ops and rejected arithmetic go EXEC, DONE;
// a memory read adds MEM; add/sub and a compare of two general registers wait in
// ALU for the shared unit, as do mul/div (8 steps of the shared ALU).
// Next transaction accepted once DONE has loaded the output register; a full one stalls DONE.
// Reset: control and architectural registers clear at once; the data memory is then cleared.
`timescale 1ns / 1ps
`include "toy_cpu_register_alu_step_assert.svh"

module toy_cpu_register_alu_step
    import tcpu_pkg::*;
#(
    parameter int MEM_DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] op,
    input  logic [2:0] reg_sel,
    input  logic [2:0] reg_sel_b,
    input  logic [7:0] value,
    input  logic [7:0] addr,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic [7:0] pc_now,
    output logic [7:0] flag_now,
    output logic       error
);

    state_t     state_reg, state_next;

    // architectural state
    logic [7:0] gen_reg [GEN_REGS];
    logic [7:0] gen_next [GEN_REGS];
    logic [7:0] sp_reg, sp_next;
    logic [7:0] bp_reg, bp_next;
    logic [7:0] pc_reg, pc_next;
    logic [7:0] flag_reg, flag_next;

    // latched instruction
    op_t        op_q_reg, op_q_next;
    logic [2:0] ra_q_reg, ra_q_next;
    logic [2:0] rb_q_reg, rb_q_next;
    logic [7:0] val_q_reg, val_q_next;
    logic [7:0] addr_q_reg, addr_q_next;
    logic [7:0] rd_reg, rd_next;
    logic       err_reg, err_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_rd_reg, out_rd_next;
    logic [7:0] out_pc_reg, out_pc_next;
    logic [7:0] out_flag_reg, out_flag_next;
    logic       out_err_reg, out_err_next;

    alu_req_t   alu_req;
    alu_rsp_t   alu_rsp;
    mem_req_t   mem_req;
    logic [7:0] mem_rdata;
    logic       mem_busy;
    logic [7:0] reg_rd;

    tcpu_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    tcpu_mem #(
        .DEPTH (MEM_DEPTH)
    ) u_mem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    // register read mux for read_reg
    always_comb
    begin
        case (ra_q_reg)
            REG_SP:   reg_rd = sp_reg;
            REG_BP:   reg_rd = bp_reg;
            REG_PC:   reg_rd = pc_reg;
            REG_FLAG: reg_rd = flag_reg;
            default:  reg_rd = gen_reg[ra_q_reg[1:0]];
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    // sequencer: next state, state updates, unit requests
    always_comb
    begin
        state_next     = state_reg;
        gen_next       = gen_reg;
        sp_next        = sp_reg;
        bp_next        = bp_reg;
        pc_next        = pc_reg;
        flag_next      = flag_reg;
        op_q_next      = op_q_reg;
        ra_q_next      = ra_q_reg;
        rb_q_next      = rb_q_reg;
        val_q_next     = val_q_reg;
        addr_q_next    = addr_q_reg;
        rd_next        = rd_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_rd_next    = out_rd_reg;
        out_pc_next    = out_pc_reg;
        out_flag_next  = out_flag_reg;
        out_err_next   = out_err_reg;
        alu_req        = '0;
        mem_req        = '0;
        mem_req.addr   = addr_q_reg;
        mem_req.wdata  = val_q_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!mem_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_q_next   = op_t'(op);
                    ra_q_next   = reg_sel;
                    rb_q_next   = reg_sel_b;
                    val_q_next  = value;
                    addr_q_next = addr;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                rd_next    = 8'd0;
                err_next   = 1'b0;
                state_next = ST_DONE;
                unique case (op_q_reg) inside
                    OP_STORE:
                    begin
                        pc_next = pc_reg + 8'd1;
                        case (ra_q_reg)
                            REG_SP:   sp_next   = val_q_reg;
                            REG_BP:   bp_next   = val_q_reg;
                            REG_PC:   pc_next   = val_q_reg + 8'd1;
                            REG_FLAG: flag_next = val_q_reg;
                            default:  gen_next[ra_q_reg[1:0]] = val_q_reg;
                        endcase
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    begin
                        if (ra_q_reg[2] || (op_q_reg == OP_DIV && val_q_reg == 8'd0))
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            alu_req.start = 1'b1;
                            alu_req.a     = gen_reg[ra_q_reg[1:0]];
                            alu_req.b     = val_q_reg;
                            case (op_q_reg)
                                OP_ADD:  alu_req.op = ALU_ADD;
                                OP_SUB:  alu_req.op = ALU_SUB;
                                OP_MUL:  alu_req.op = ALU_MUL;
                                default: alu_req.op = ALU_DIV;
                            endcase
                            state_next = ST_ALU;
                        end
                    end
                    OP_JUMP:
                    begin
                        pc_next = addr_q_reg;
                    end
                    OP_JIF:
                    begin
                        if (flag_reg != 8'd0)
                        begin
                            pc_next = addr_q_reg;
                        end
                    end
                    OP_CMP:
                    begin
                        // equality by subtraction on the shared unit
                        if (!ra_q_reg[2] && !rb_q_reg[2] && ra_q_reg != rb_q_reg)
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_SUB;
                            alu_req.a     = gen_reg[ra_q_reg[1:0]];
                            alu_req.b     = gen_reg[rb_q_reg[1:0]];
                            state_next    = ST_ALU;
                        end
                        else
                        begin
                            pc_next = pc_reg + 8'd1;
                        end
                    end
                    OP_WMEM:
                    begin
                        mem_req.we = 1'b1;
                    end
                    OP_RMEM:
                    begin
                        mem_req.re = 1'b1;
                        state_next = ST_MEM;
                    end
                    OP_RREG:
                    begin
                        rd_next = reg_rd;
                    end
                    OP_HALT:
                    begin
                        pc_next = pc_reg + 8'd1;
                    end
                    default:
                    begin
                        pc_next = pc_reg;
                    end
                endcase
            end
            ST_ALU:
            begin
                if (alu_rsp.done)
                begin
                    pc_next    = pc_reg + 8'd1;
                    state_next = ST_DONE;
                    if (op_q_reg == OP_CMP)
                    begin
                        if (alu_rsp.result == 8'd0)
                        begin
                            flag_next = 8'd1;
                        end
                    end
                    else
                    begin
                        gen_next[ra_q_reg[1:0]] = alu_rsp.result;
                    end
                end
            end
            ST_MEM:
            begin
                rd_next    = mem_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = rd_reg;
                    out_pc_next    = pc_reg;
                    out_flag_next  = flag_reg;
                    out_err_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            sp_reg        <= 8'd0;
            bp_reg        <= 8'd0;
            pc_reg        <= 8'd0;
            flag_reg      <= 8'd0;
            for (int i = 0; i < GEN_REGS; i++)
            begin
                gen_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sp_reg        <= sp_next;
            bp_reg        <= bp_next;
            pc_reg        <= pc_next;
            flag_reg      <= flag_next;
            gen_reg       <= gen_next;
        end
    end

    // transaction payload
    always_ff @(posedge clk)
    begin
        op_q_reg     <= op_q_next;
        ra_q_reg     <= ra_q_next;
        rb_q_reg     <= rb_q_next;
        val_q_reg    <= val_q_next;
        addr_q_reg   <= addr_q_next;
        rd_reg       <= rd_next;
        err_reg      <= err_next;
        out_rd_reg   <= out_rd_next;
        out_pc_reg   <= out_pc_next;
        out_flag_reg <= out_flag_next;
        out_err_reg  <= out_err_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_rd_reg;
    assign pc_now    = out_pc_reg;
    assign flag_now  = out_flag_reg;
    assign error     = out_err_reg;

    // ALU completion only lands while the sequencer waits for it
    `TCPU_ASSERT_NEVER(a_alu_done_state, clk, rst_n, alu_rsp.done && state_reg != ST_ALU)
    // memory clearing pass only while no transaction can be accepted
    `TCPU_ASSERT(a_clear_blocks, clk, rst_n, mem_busy |-> state_reg == ST_CLEAR)
    // pc moves only while an instruction executes
    `TCPU_ASSERT(a_pc_hold, clk, rst_n, (state_reg == ST_IDLE || state_reg == ST_DONE) |=> $stable(pc_reg))

endmodule
